// ----- rtl/core/wfpd_pkg.sv -----
// wall follow pd steering package: register indexes, reset values, fixed push
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package wfpd_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned DistW    = 8;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_DERIV_GAIN  = 3'd1,
    REG_ALIGN_GAIN  = 3'd2,
    REG_OUTPUT_LIM  = 3'd3,
    REG_ALIGN_LIM   = 3'd4,
    REG_NEAR_THRESH = 3'd5,
    REG_OPEN_THRESH = 3'd6,
    REG_SHORT_THRESH = 3'd7
  } cfg_reg_e;

  localparam logic [5:0] PropGainRst   = 6'd5;
  localparam logic [5:0] DerivGainRst  = 6'd18;
  localparam logic [5:0] AlignGainRst  = 6'd1;
  localparam logic [6:0] OutputLimRst  = 7'd22;
  localparam logic [6:0] AlignLimRst   = 7'd6;
  localparam logic [7:0] NearThreshRst = 8'd20;
  localparam logic [7:0] OpenThreshRst = 8'd80;
  localparam logic [7:0] ShortThreshRst = 8'd17;

  localparam logic [7:0] FixedPush = 8'd7;

  localparam logic WallRight = 1'b0;
  localparam logic WallLeft  = 1'b1;

endpackage

`default_nettype wire

// ----- rtl/core/wall_follow_pd_steering.sv -----
// wall following pd steering core, one word in and one word out per cycle when not stalled
// depends on wfpd_pkg
//
//  channel   signals                                 direction
//  in        in_valid_i / in_ready_o, six distances  sensor words in
//  out       out_valid_o / out_ready_i, steer, wall  steering words out
//  cfg       cfg_we_i, cfg_idx_i, cfg_data_i          register writes
//
// an input word is registered, the whole steering law is evaluated
// combinationally from that register into the result register, one word per
// cycle when not stalled. the previous side differences advance as a word
// moves into the result register. reset loads the default gains and
// thresholds and clears the stored differences. a stalled result holds the
// input register, and the input side stays ready while either stage can move.
`timescale 1ns / 1ps
`default_nettype none

module wall_follow_pd_steering
  import wfpd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,

  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,

  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [DistW-1:0]    left_front_dist_i,
  input  wire logic [DistW-1:0]    left_back_dist_i,
  input  wire logic [DistW-1:0]    right_front_dist_i,
  input  wire logic [DistW-1:0]    right_back_dist_i,
  input  wire logic [DistW-1:0]    short_left_dist_i,
  input  wire logic [DistW-1:0]    short_right_dist_i,

  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic signed [7:0]        steer_value_o,
  output logic                     followed_wall_o
);

  // configuration registers
  logic [5:0] kp_q, kd_q, ka_q;
  logic [6:0] out_lim_q, align_lim_q;
  logic [7:0] near_q, open_q, short_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q        <= PropGainRst;
      kd_q        <= DerivGainRst;
      ka_q        <= AlignGainRst;
      out_lim_q   <= OutputLimRst;
      align_lim_q <= AlignLimRst;
      near_q      <= NearThreshRst;
      open_q      <= OpenThreshRst;
      short_q     <= ShortThreshRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_PROP_GAIN:    kp_q        <= cfg_data_i[5:0];
        REG_DERIV_GAIN:   kd_q        <= cfg_data_i[5:0];
        REG_ALIGN_GAIN:   ka_q        <= cfg_data_i[5:0];
        REG_OUTPUT_LIM:   out_lim_q   <= cfg_data_i[6:0];
        REG_ALIGN_LIM:    align_lim_q <= cfg_data_i[6:0];
        REG_NEAR_THRESH:  near_q      <= cfg_data_i;
        REG_OPEN_THRESH:  open_q      <= cfg_data_i;
        REG_SHORT_THRESH: short_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake between the two stages
  logic s1_valid_q;
  logic out_valid_q;
  logic out_free;
  logic advance;
  logic in_take;

  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_take    = in_valid_i && in_ready_o;

  // input register
  logic [7:0] lf_q, lb_q, rf_q, rb_q, sl_q, sr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      lf_q <= left_front_dist_i;
      lb_q <= left_back_dist_i;
      rf_q <= right_front_dist_i;
      rb_q <= right_back_dist_i;
      sl_q <= short_left_dist_i;
      sr_q <= short_right_dist_i;
    end
  end

  // steering law
  logic [7:0] prev_r_q, prev_l_q;
  logic [7:0] dl, dr, cf, cb;
  logic       left_near, right_near, crossing, nearer_right, wall;
  logic [7:0] p_term, d_delta, d_term, pd_val, corr_val, pre_clamp;
  logic signed [16:0] sum_c, ka_s, prod_c, neg_c, half_c;
  logic signed [8:0]  t9, alim9, v9, olim9;
  logic [7:0] t_clamped;
  logic [7:0] steer_d;

  always_comb begin
    dl = lf_q - 8'd1 - lb_q;
    dr = rf_q - rb_q;
    cf = rf_q - lf_q + 8'd1;
    cb = rb_q - lb_q;

    left_near    = (lf_q <= near_q) && (lb_q <= near_q);
    right_near   = (rf_q <= near_q) && (rb_q <= near_q);
    crossing     = (lf_q > open_q) || (rf_q > open_q);
    nearer_right = ({1'b0, rf_q} + {1'b0, rb_q}) < ({1'b0, lf_q} + {1'b0, lb_q});

    if (left_near || (lf_q > open_q)) begin
      wall = WallRight;
    end else if (right_near || (rf_q > open_q)) begin
      wall = WallLeft;
    end else begin
      wall = nearer_right ? WallRight : WallLeft;
    end

    // pd term, everything modulo 256
    if (wall == WallRight) begin
      p_term  = 8'({2'b00, kp_q} * dr);
      d_delta = dr - prev_r_q;
      d_term  = 8'({2'b00, kd_q} * d_delta);
      pd_val  = 8'd0 - p_term - d_term;
    end else begin
      p_term  = 8'({2'b00, kp_q} * dl);
      d_delta = dl - prev_l_q;
      d_term  = 8'({2'b00, kd_q} * d_delta);
      pd_val  = p_term + d_term;
    end

    // centering term, exact product then halve toward zero
    sum_c  = 17'($signed(cf)) + 17'($signed(cb));
    ka_s   = {11'd0, ka_q};
    prod_c = sum_c * ka_s;
    neg_c  = -prod_c;
    half_c = (neg_c + {16'd0, neg_c[16]}) >>> 1;
    t9     = 9'($signed(half_c[7:0]));
    alim9  = {2'b00, align_lim_q};
    if (t9 > alim9) begin
      t_clamped = {1'b0, align_lim_q};
    end else if (t9 < -alim9) begin
      t_clamped = 8'd0 - {1'b0, align_lim_q};
    end else begin
      t_clamped = half_c[7:0];
    end

    if (left_near) begin
      corr_val = pd_val - FixedPush;
    end else if (right_near) begin
      corr_val = pd_val + FixedPush;
    end else if (!crossing) begin
      corr_val = pd_val + t_clamped;
    end else begin
      corr_val = pd_val;
    end

    if (sr_q < short_q) begin
      pre_clamp = FixedPush;
    end else if (sl_q < short_q) begin
      pre_clamp = 8'd0 - FixedPush;
    end else begin
      pre_clamp = corr_val;
    end

    v9    = 9'($signed(pre_clamp));
    olim9 = {2'b00, out_lim_q};
    if (v9 > olim9) begin
      steer_d = {1'b0, out_lim_q};
    end else if (v9 < -olim9) begin
      steer_d = 8'd0 - {1'b0, out_lim_q};
    end else begin
      steer_d = pre_clamp;
    end
  end

  // result register and stored differences
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      prev_r_q    <= 8'd0;
      prev_l_q    <= 8'd0;
    end else begin
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
      if (advance) begin
        prev_r_q <= dr;
        prev_l_q <= dl;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      steer_value_o   <= $signed(steer_d);
      followed_wall_o <= wall;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire
